FILE: src/mms_pkg.sv
// Shared constants and types for the min/max stack without duplicates.
`default_nettype none

package mms_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MAXC,
    ST_MINC,
    ST_WRITE,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: src/mms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/mms_cmp.sv
// Shared comparator: equality and signed less-than.
`default_nettype none

module mms_cmp (
  input  wire logic [mms_pkg::DATA_W-1:0] a,
  input  wire logic [mms_pkg::DATA_W-1:0] b,
  output mms_pkg::cmp_res_t               res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = ($signed(a) < $signed(b));
  end

endmodule

`default_nettype wire

FILE: src/min_max_stack_no_duplicates.sv
// Top level: min/max stack with duplicate rejection, sequenced over one comparator.
// Commands are taken one at a time in idle. Push: duplicate scan, drain, max and min
//   compares, write, fetch, result; after the drain a duplicate (checked before full)
//   or a full stack skips to the fetch. The duplicate scan reads the value memory one
//   entry per cycle on its read port. Push on empty skips the scan; pops, also on empty, go to the fetch.
// Reset (synchronous, active high) clears the entry count, sequencer and output
//   valid; the memories are not cleared, and no entry at or above the count is used.
`default_nettype none

module min_max_stack_no_duplicates (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic                                     func,
  input  wire logic signed [mms_pkg::DATA_W-1:0]        value,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic        [1:0]                             status,
  output logic signed [mms_pkg::DATA_W-1:0]             top_value,
  output logic signed [mms_pkg::DATA_W-1:0]             top_max,
  output logic signed [mms_pkg::DATA_W-1:0]             top_min,
  output logic                                          is_empty,
  output logic        [mms_pkg::COUNT_OUT_W-1:0]        entry_count
);

  mms_pkg::state_t                 state, state_next;
  logic [mms_pkg::CNT_W-1:0]       count, count_next;
  logic [mms_pkg::CNT_W-1:0]       idx;
  logic [mms_pkg::ADDR_W-1:0]      top_addr;
  logic [mms_pkg::ADDR_W-1:0]      val_raddr;
  logic [mms_pkg::DATA_W-1:0]      val_rdata;
  logic [2*mms_pkg::DATA_W-1:0]    mm_rdata;
  logic [mms_pkg::DATA_W-1:0]      top_mx, top_mn;
  logic [mms_pkg::DATA_W-1:0]      push_value;
  logic [mms_pkg::DATA_W-1:0]      mx, mn;
  logic [mms_pkg::DATA_W-1:0]      cmp_a, cmp_b;
  mms_pkg::cmp_res_t               cmp;
  mms_pkg::status_t                stat;
  logic                            pend;
  logic                            dup;
  logic                            dup_hit;
  logic                            full;
  logic                            empty;
  logic                            in_fire;
  logic                            out_free;
  logic                            wr_en;
  logic                            out_valid_next;

  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign top_addr = mms_pkg::ADDR_W'(count - mms_pkg::CNT_W'(1));
  assign full     = (count == mms_pkg::CNT_W'(mms_pkg::STACK_DEPTH));
  assign empty    = (count == '0);
  assign dup_hit  = dup | (pend & cmp.eq);
  assign top_mx   = mm_rdata[2*mms_pkg::DATA_W-1:mms_pkg::DATA_W];
  assign top_mn   = mm_rdata[mms_pkg::DATA_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mms_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (func == mms_pkg::OP_PUSH) begin
            state_next = empty ? mms_pkg::ST_MAXC : mms_pkg::ST_SCAN;
          end else begin
            state_next = mms_pkg::ST_FETCH;
          end
        end
      end
      mms_pkg::ST_SCAN: begin
        if (idx == count - mms_pkg::CNT_W'(1)) begin
          state_next = mms_pkg::ST_DRAIN;
        end
      end
      mms_pkg::ST_DRAIN: begin
        state_next = (dup_hit || full) ? mms_pkg::ST_FETCH : mms_pkg::ST_MAXC;
      end
      mms_pkg::ST_MAXC:  state_next = mms_pkg::ST_MINC;
      mms_pkg::ST_MINC:  state_next = mms_pkg::ST_WRITE;
      mms_pkg::ST_WRITE: state_next = mms_pkg::ST_FETCH;
      mms_pkg::ST_FETCH: state_next = mms_pkg::ST_DONE;
      mms_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mms_pkg::ST_IDLE;
        end
      end
      default: state_next = mms_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready       = (state == mms_pkg::ST_IDLE);
    wr_en          = (state == mms_pkg::ST_WRITE);
    val_raddr      = top_addr;
    cmp_a          = val_rdata;
    cmp_b          = push_value;
    count_next     = count;
    out_valid_next = out_valid & ~out_ready;
    case (state)
      mms_pkg::ST_IDLE: begin
        if (in_fire && func == mms_pkg::OP_POP && !empty) begin
          count_next = count - mms_pkg::CNT_W'(1);
        end
      end
      mms_pkg::ST_SCAN: begin
        val_raddr = idx[mms_pkg::ADDR_W-1:0];
      end
      mms_pkg::ST_MAXC: begin
        cmp_a = top_mx;
        cmp_b = push_value;
      end
      mms_pkg::ST_MINC: begin
        cmp_a = push_value;
        cmp_b = top_mn;
      end
      mms_pkg::ST_WRITE: begin
        count_next = count + mms_pkg::CNT_W'(1);
      end
      mms_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  mms_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  mms_ram #(
    .WIDTH (mms_pkg::DATA_W),
    .DEPTH (mms_pkg::STACK_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[mms_pkg::ADDR_W-1:0]),
    .wdata (push_value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // running max/min per entry; read address always tracks the top entry
  mms_ram #(
    .WIDTH (2 * mms_pkg::DATA_W),
    .DEPTH (mms_pkg::STACK_DEPTH)
  ) u_mm_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[mms_pkg::ADDR_W-1:0]),
    .wdata ({mx, mn}),
    .raddr (top_addr),
    .rdata (mm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mms_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      pend      <= (state == mms_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      push_value <= value;
      idx        <= '0;
      dup        <= 1'b0;
      stat       <= (func == mms_pkg::OP_POP && empty) ? mms_pkg::STAT_EMPTY
                                                      : mms_pkg::STAT_DONE;
    end
    if (state == mms_pkg::ST_SCAN) begin
      idx <= idx + mms_pkg::CNT_W'(1);
    end
    // compare word read on the previous cycle
    if (pend && cmp.eq) begin
      dup <= 1'b1;
    end
    if (state == mms_pkg::ST_DRAIN) begin
      stat <= dup_hit ? mms_pkg::STAT_DUP :
              full    ? mms_pkg::STAT_FULL : mms_pkg::STAT_DONE;
    end
    if (state == mms_pkg::ST_MAXC) begin
      mx <= (empty || cmp.lt) ? push_value : top_mx;
    end
    if (state == mms_pkg::ST_MINC) begin
      mn <= (empty || cmp.lt) ? push_value : top_mn;
    end
    if (state == mms_pkg::ST_DONE && out_free) begin
      status      <= stat;
      is_empty    <= empty;
      entry_count <= mms_pkg::COUNT_OUT_W'(count);
      top_value   <= empty ? '0 : val_rdata;
      top_max     <= empty ? '0 : top_mx;
      top_min     <= empty ? '0 : top_mn;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mms_pkg::CNT_W'(mms_pkg::STACK_DEPTH))
    else $error("entry count above stack depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != mms_pkg::ST_WRITE && !(in_fire && func == mms_pkg::OP_POP)) |=> $stable(count))
    else $error("entry count changed outside write or pop");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (state == mms_pkg::ST_WRITE) |-> !full)
    else $error("write into a full stack");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mms_pkg::STAT_FULL) |->
      (entry_count == mms_pkg::COUNT_OUT_W'(mms_pkg::STACK_DEPTH)))
    else $error("full status without a full entry count");

endmodule

`default_nettype wire

FILE: tb/min_max_stack_no_duplicates_tb.sv
// Self-checking testbench for the min/max stack with duplicate rejection.
`default_nettype none

module min_max_stack_no_duplicates_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mms_pkg::*;

  localparam int TOTAL_WORDS = 1300;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct {
    status_t                  status;
    word_t                    top_value;
    word_t                    top_max;
    word_t                    top_min;
    logic                     is_empty;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } stack_view_t;

  // Shadow stack: tracks contents and running max/min, queues the view after each word.
  class stack_scoreboard;
    word_t       vals[STACK_DEPTH];
    word_t       maxs[STACK_DEPTH];
    word_t       mins[STACK_DEPTH];
    int unsigned depth_now = 0;
    stack_view_t pending_views[$];
    int unsigned errors = 0;

    function bit holds(word_t v);
      for (int unsigned i = 0; i < depth_now; i++) begin
        if (vals[i] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void apply_word(op_t op, word_t v);
      stack_view_t view;
      status_t     st;
      word_t       mx;
      word_t       mn;
      if (op == OP_PUSH) begin
        // a held value is rejected before the full test
        if (holds(v)) st = STAT_DUP;
        else if (depth_now >= STACK_DEPTH) st = STAT_FULL;
        else begin
          mx = v;
          mn = v;
          if (depth_now > 0) begin
            mx = maxs[depth_now-1];
            mn = mins[depth_now-1];
            if (v > mx) mx = v;
            if (v < mn) mn = v;
          end
          vals[depth_now] = v;
          maxs[depth_now] = mx;
          mins[depth_now] = mn;
          depth_now++;
          st = STAT_DONE;
        end
      end else if (depth_now == 0) begin
        st = STAT_EMPTY;
      end else begin
        depth_now--;
        st = STAT_DONE;
      end
      view.status = st;
      if (depth_now > 0) begin
        view.top_value = vals[depth_now-1];
        view.top_max   = maxs[depth_now-1];
        view.top_min   = mins[depth_now-1];
        view.is_empty  = 1'b0;
      end else begin
        view.top_value = '0;
        view.top_max   = '0;
        view.top_min   = '0;
        view.is_empty  = 1'b1;
      end
      view.entry_count = depth_now[COUNT_OUT_W-1:0];
      pending_views.push_back(view);
    endfunction

    function void diff(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, exp_v, got_v);
      end
    endfunction

    function void check_view(stack_view_t got);
      stack_view_t want;
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual status %h top %h",
                 $realtime, got.status, got.top_value);
        return;
      end
      want = pending_views.pop_front();
      diff("status", 32'(want.status), 32'(got.status));
      diff("top_value", want.top_value, got.top_value);
      diff("top_max", want.top_max, got.top_max);
      diff("top_min", want.top_min, got.top_min);
      diff("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      diff("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction

    function int unsigned pending();
      return pending_views.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = OP_PUSH;
  word_t                  value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  word_t                  top_value;
  word_t                  top_max;
  word_t                  top_min;
  logic                   is_empty;
  logic [COUNT_OUT_W-1:0] entry_count;

  stack_scoreboard sb = new;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned rdy_mode = 0;
  int unsigned rdy_span = 0;

  min_max_stack_no_duplicates u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .top_value   (top_value),
    .top_max     (top_max),
    .top_min     (top_min),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: check each accepted result word, then pick next cycle's ready
  always @(posedge clk) begin
    stack_view_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.status      = status_t'(status);
        got.top_value   = top_value;
        got.top_max     = top_max;
        got.top_min     = top_min;
        got.is_empty    = is_empty;
        got.entry_count = entry_count;
        sb.check_view(got);
      end
      if (rdy_span == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_span = $urandom_range(5, 60);
      end
      rdy_span--;
      case (rdy_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  task automatic send_word(input op_t op, input word_t v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func     <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.apply_word(op, v);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic word_t fresh_value();
    word_t v;
    do v = $urandom; while (sb.holds(v));
    return v;
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: begin
        if (sb.depth_now > 0 && $urandom_range(0, 2) == 0)
          return sb.vals[$urandom_range(0, sb.depth_now - 1)];
        return $urandom;
      end
    endcase
  endfunction

  // mostly distinct pushes up to full, then a few pushes that hit dup or full
  task automatic fill_up();
    while (sb.depth_now < STACK_DEPTH) begin
      if (sb.depth_now > 0 && $urandom_range(0, 6) == 0)
        send_word(OP_PUSH, sb.vals[$urandom_range(0, sb.depth_now - 1)]);
      else
        send_word(OP_PUSH, fresh_value());
    end
    repeat ($urandom_range(2, 5)) begin
      if ($urandom_range(0, 1) == 0)
        send_word(OP_PUSH, sb.vals[$urandom_range(0, sb.depth_now - 1)]);
      else
        send_word(OP_PUSH, fresh_value());
    end
  endtask

  task automatic drain_all();
    while (sb.depth_now > 0) send_word(OP_POP, $urandom);
    repeat ($urandom_range(1, 3)) send_word(OP_POP, $urandom);
  endtask

  task automatic mixed_ops(input int unsigned n, input bit tiny);
    word_t v;
    repeat (n) begin
      if ($urandom_range(0, 99) < 58) begin
        v = tiny ? word_t'($signed($urandom_range(0, 8)) - 4) : pick_value();
        send_word(OP_PUSH, v);
      end else begin
        send_word(OP_POP, $urandom);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pops, extremes, duplicates of extremes, unwinding
    send_word(OP_POP, 32'sh12345678);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, 32'sh7fffffff);
    send_word(OP_PUSH, 32'sh80000000);
    send_word(OP_PUSH, -1);
    send_word(OP_PUSH, 32'sh7fffffff);
    send_word(OP_PUSH, 32'sh80000000);
    send_word(OP_PUSH, 1);
    send_word(OP_PUSH, -2);
    repeat (6) send_word(OP_POP, -1);
    send_word(OP_POP, '0);
    send_word(OP_PUSH, -5);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    wait_drained();

    // first random phase always reaches full
    fill_up();
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 5))
        0, 1: fill_up();
        2: drain_all();
        3, 4: mixed_ops(40, 1'b0);
        default: mixed_ops(30, 1'b1);
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/mms_pkg.sv
src/mms_ram.sv
src/mms_cmp.sv
src/min_max_stack_no_duplicates.sv
tb/min_max_stack_no_duplicates_tb.sv
